// ----- src/nmea_gga_position_parser_assert.svh -----
// ----------------------------------------------------------------------------
// NMEA GGA position parser assertion macros
// Concurrent assertion wrappers on clk; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef NMEA_GGA_POSITION_PARSER_ASSERT_SVH
`define NMEA_GGA_POSITION_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// checked outside reset only
`define NGP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define NGP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NGP_ASSERT(label, prop, msg)
`define NGP_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- src/nmea_gga_pkg.sv -----
// ----------------------------------------------------------------------------
// NMEA GGA parser package
// Character codes, field numbers, conversion constants and helpers.
// ----------------------------------------------------------------------------
package nmea_gga_pkg;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;

    localparam logic [2:0] HDR_LEN   = 3'd6;
    localparam logic [2:0] FIELD_LAT = 3'd2;
    localparam logic [2:0] FIELD_NS  = 3'd3;
    localparam logic [2:0] FIELD_LON = 3'd4;
    localparam logic [2:0] FIELD_EW  = 3'd5;
    localparam logic [2:0] FIELD_FIX = 3'd6;
    localparam logic [2:0] FIELD_MAX = 3'd7;

    // whole degrees, 200 is the saturation value of a coordinate
    localparam logic [7:0] DEG_CAP   = 8'd200;
    localparam logic [7:0] LAT_LIMIT = 8'd90;
    localparam logic [7:0] LON_LIMIT = 8'd180;

    localparam int LAT_W = 31;
    localparam int LON_W = 32;
    // scaled minutes, always below 1e9
    localparam int X_W   = 30;
    // minutes part in 1e-7 degree, below 1e9 / 60
    localparam int Q_W   = 25;

    // floor(y / 15) = (y * RECIP15) >> 32 for y < 2^28
    localparam logic [28:0] RECIP15     = 29'd286331154;
    localparam int          RECIP_SHIFT = 32;
    localparam logic [31:0] DEG_UNIT    = 32'd10000000;

    typedef struct packed {
        logic ok;
        logic south;
        logic west;
    } line_status_t;

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h24;  // $
            3'd1:    c = 8'h47;  // G
            3'd2:    c = 8'h50;  // P
            3'd3:    c = 8'h47;  // G
            3'd4:    c = 8'h47;  // G
            3'd5:    c = 8'h41;  // A
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic longint unsigned pow10(input int unsigned n);
        longint unsigned r;
        r = 1;
        for (int i = 0; i < 8; i++)
        begin
            if (i < n)
                r = r * 10;
        end
        return r;
    endfunction

    // hundreds digit of a value below 1000
    function automatic logic [3:0] hundreds(input logic [9:0] v);
        logic [3:0] q;
        q = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (v >= 10'(100 * k))
                q = 4'(k);
        end
        return q;
    endfunction

endpackage

// ----- src/nmea_gga_position_parser.sv -----
// ----------------------------------------------------------------------------
// NMEA GGA position parser
// Byte-stream GGA sentence checker with position output in 1e-7 degree.
// ----------------------------------------------------------------------------
// Usage:
//  rx channel (rx_valid/rx_ready/rx_byte) takes one character per cycle while rx_ready is high.
//  Every line feed produces exactly one result on the res channel
//  (res_valid/res_ready): accepted, latitude, longitude. Other characters
//  produce nothing. Leading blanks are skipped, the line must open with
//  $GPGGA, text after '*' is ignored.
//  Throughput: one character per cycle, sustained, as long as results drain.
//  A line feed is captured in the first stage register and its result reaches
//  res_valid through four conversion stages (minutes assembly, range
//  check and scaling, reciprocal multiply for the divide by 60, degree
//  combine and sign) into the result register.
//  If res_ready stays low, up to five results queue in the stages and the
//  result register; rx_ready drops only once the first stage cannot move.
//  Reset clears the line state and empties all stages; no result is pending.
// ----------------------------------------------------------------------------
`include "nmea_gga_position_parser_assert.svh"

module nmea_gga_position_parser #(
    parameter int FRAC_DIGITS = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_ready,
    input  logic [7:0]         rx_byte,
    output logic               res_valid,
    input  logic               res_ready,
    output logic               accepted,
    output logic signed [30:0] latitude,
    output logic signed [31:0] longitude
);
    import nmea_gga_pkg::*;

    localparam longint unsigned P = pow10(FRAC_DIGITS);
    localparam int FW = $clog2(P);
    localparam int MW = $clog2(100 * P);
    localparam logic [MW-1:0]  P_M     = MW'(P);
    localparam logic [MW-1:0]  P60     = MW'(60 * P);
    localparam logic [X_W-1:0] SCALE_X = X_W'(pow10(7 - FRAC_DIGITS));

    // index 0 is latitude, 1 is longitude
    line_status_t scan_status;
    logic [7:0]    scan_deg [2];
    logic [6:0]    scan_mm [2];
    logic [FW-1:0] scan_frac [2];

    logic fire, is_lf;
    logic en1, en2, en3, en4, out_en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;

    line_status_t  st1_reg, st2_reg, st3_reg, st4_reg;
    logic [7:0]    deg1_reg [2], deg2_reg [2], deg3_reg [2], deg4_reg [2];
    logic [6:0]    mm1_reg [2];
    logic [FW-1:0] frac1_reg [2];
    logic [MW-1:0] m2_reg [2];
    logic [X_W-1:0] x3_reg [2];
    logic [Q_W-1:0] q4_reg [2];

    logic [MW-1:0]  m_c [2];
    logic [X_W-1:0] x_c [2];
    logic [56:0]    prod_c [2];
    logic [31:0]    r_c [2];
    logic [7:0]     limit_c [2];
    logic           range_ok [2];
    logic           ok_f;
    logic [31:0]    la, lo;

    logic                    accepted_reg, accepted_next;
    logic signed [LAT_W-1:0] latitude_reg, latitude_next;
    logic signed [LON_W-1:0] longitude_reg, longitude_next;

    nmea_gga_scan #(
        .FRAC_DIGITS(FRAC_DIGITS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .rx_byte  (rx_byte),
        .status   (scan_status),
        .lat_deg  (scan_deg[0]),
        .lat_mm   (scan_mm[0]),
        .lat_frac (scan_frac[0]),
        .lon_deg  (scan_deg[1]),
        .lon_mm   (scan_mm[1]),
        .lon_frac (scan_frac[1])
    );

    // each stage moves when empty or when the one after it moves
    always_comb
    begin
        out_en   = !out_valid_reg || res_ready;
        en4      = !v4_reg || out_en;
        en3      = !v3_reg || en4;
        en2      = !v2_reg || en3;
        en1      = !v1_reg || en2;
        rx_ready = en1;
        fire     = rx_valid && en1;
        is_lf    = rx_byte == CH_LF;
    end

    always_comb
    begin
        limit_c[0] = LAT_LIMIT;
        limit_c[1] = LON_LIMIT;
        for (int i = 0; i < 2; i++)
        begin
            m_c[i] = MW'(mm1_reg[i]) * P_M + MW'(frac1_reg[i]);

            // total minutes above limit*60: besides degrees above the limit, only the top two degree values can trip it
            priority if (deg2_reg[i] > limit_c[i])
                range_ok[i] = 1'b0;
            else if (deg2_reg[i] == limit_c[i])
                range_ok[i] = m2_reg[i] == '0;
            else if (deg2_reg[i] == limit_c[i] - 8'd1)
                range_ok[i] = m2_reg[i] <= P60;
            else
                range_ok[i] = 1'b1;
            x_c[i] = X_W'(m2_reg[i]) * SCALE_X;

            // x / 60 = (x >> 2) / 15
            prod_c[i] = 57'(x3_reg[i][X_W-1:2]) * 57'(RECIP15);

            r_c[i] = 32'(deg4_reg[i]) * DEG_UNIT + 32'(q4_reg[i]);
        end

        ok_f = st4_reg.ok && r_c[0] != 32'd0 && r_c[1] != 32'd0;
        la   = ok_f ? r_c[0] : 32'd0;
        lo   = ok_f ? r_c[1] : 32'd0;
        if (st4_reg.south)
            la = 32'd0 - la;
        if (st4_reg.west)
            lo = 32'd0 - lo;
        accepted_next  = ok_f;
        latitude_next  = LAT_W'(la);
        longitude_next = LON_W'(lo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= fire && is_lf;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
            if (out_en)
                out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            st1_reg <= scan_status;
            for (int i = 0; i < 2; i++)
            begin
                deg1_reg[i]  <= scan_deg[i];
                mm1_reg[i]   <= scan_mm[i];
                frac1_reg[i] <= scan_frac[i];
            end
        end
        if (en2)
        begin
            st2_reg <= st1_reg;
            for (int i = 0; i < 2; i++)
            begin
                deg2_reg[i] <= deg1_reg[i];
                m2_reg[i]   <= m_c[i];
            end
        end
        if (en3)
        begin
            st3_reg <= '{
                ok:    st2_reg.ok && range_ok[0] && range_ok[1],
                south: st2_reg.south,
                west:  st2_reg.west
            };
            for (int i = 0; i < 2; i++)
            begin
                deg3_reg[i] <= deg2_reg[i];
                x3_reg[i]   <= x_c[i];
            end
        end
        if (en4)
        begin
            st4_reg <= st3_reg;
            for (int i = 0; i < 2; i++)
            begin
                deg4_reg[i] <= deg3_reg[i];
                q4_reg[i]   <= prod_c[i][RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
            end
        end
        if (out_en)
        begin
            accepted_reg  <= accepted_next;
            latitude_reg  <= latitude_next;
            longitude_reg <= longitude_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign accepted  = accepted_reg;
    assign latitude  = latitude_reg;
    assign longitude = longitude_reg;

    `NGP_ASSERT_ALWAYS(a_reject_zero, (res_valid && !accepted) |-> (latitude == 0 && longitude == 0), "rejected line carries a position")
    `NGP_ASSERT(a_accept_nonzero, (res_valid && accepted) |-> (latitude != 0 && longitude != 0), "accepted line with zero coordinate")
    `NGP_ASSERT(a_lat_range, res_valid |-> (latitude <= 31'sd900000000 && latitude >= -31'sd900000000), "latitude beyond 90 degrees")
    `NGP_ASSERT(a_lf_enters, (rx_valid && rx_ready && rx_byte == CH_LF) |=> v1_reg, "line feed lost before first stage")
    `NGP_ASSERT(a_stall_full, !rx_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && out_valid_reg), "input stalled with a free stage")

endmodule

// ----- src/nmea_gga_scan.sv -----
// ----------------------------------------------------------------------------
// NMEA GGA line scanner
// Per-character sentence state: header match, field split, coordinate digit
// accumulation as degrees, minutes and fraction, hemisphere and fix checks.
// ----------------------------------------------------------------------------
module nmea_gga_scan #(
    parameter  int FRAC_DIGITS = 5,
    localparam int FW = $clog2(nmea_gga_pkg::pow10(FRAC_DIGITS))
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  logic [7:0]                 rx_byte,
    output nmea_gga_pkg::line_status_t status,
    output logic [7:0]                 lat_deg,
    output logic [6:0]                 lat_mm,
    output logic [FW-1:0]              lat_frac,
    output logic [7:0]                 lon_deg,
    output logic [6:0]                 lon_mm,
    output logic [FW-1:0]              lon_frac
);
    import nmea_gga_pkg::*;

    localparam int CW = $clog2(FRAC_DIGITS + 1);

    logic [2:0]    hdr_reg, hdr_next;
    logic          started_reg, started_next;
    logic          rejected_reg, rejected_next;
    logic          star_reg, star_next;
    logic [2:0]    field_reg, field_next;
    logic          first_reg, first_next;
    logic          dot_reg, dot_next;
    logic          digit_reg, digit_next;
    logic [CW-1:0] fcount_reg, fcount_next;
    logic [7:0]    lat_deg_reg, lat_deg_next, lon_deg_reg, lon_deg_next;
    logic [6:0]    lat_mm_reg, lat_mm_next, lon_mm_reg, lon_mm_next;
    logic [FW-1:0] lat_frac_reg, lat_frac_next, lon_frac_reg, lon_frac_next;
    logic          lat_bad_reg, lat_bad_next, lon_bad_reg, lon_bad_next;
    logic          south_reg, south_next, west_reg, west_next;
    logic          fix_nz_reg, fix_nz_next, fix_bad_reg, fix_bad_next;

    logic          is_lf, is_blank, is_digit, sel_lon;
    logic [3:0]    d;
    logic [7:0]    cur_deg, deg_new;
    logic [6:0]    cur_mm, mm_new, mm_wide;
    logic [FW-1:0] cur_frac, frac_new, weight;
    logic [9:0]    cmb;
    logic [3:0]    carry;
    logic [10:0]   deg_wide;
    logic          sat;

    // shared digit unit for whichever coordinate field is open
    always_comb
    begin
        is_lf    = rx_byte == CH_LF;
        is_blank = rx_byte == CH_SPACE || (rx_byte >= CH_TAB && rx_byte <= CH_CR);
        is_digit = rx_byte >= CH_ZERO && rx_byte <= CH_NINE;
        d        = 4'(rx_byte - CH_ZERO);
        sel_lon  = field_reg == FIELD_LON;
        cur_deg  = sel_lon ? lon_deg_reg : lat_deg_reg;
        cur_mm   = sel_lon ? lon_mm_reg : lat_mm_reg;
        cur_frac = sel_lon ? lon_frac_reg : lat_frac_reg;

        // ddmm * 10 + d, carried into degrees through the minutes pair
        cmb      = 10'(cur_mm) * 10'd10 + 10'(d);
        carry    = hundreds(cmb);
        deg_wide = 11'(cur_deg) * 11'd10 + 11'(carry);
        mm_wide  = 7'(cmb - 10'(carry) * 10'd100);
        sat      = deg_wide > 11'(DEG_CAP) || (deg_wide == 11'(DEG_CAP) && mm_wide != 7'd0);
        deg_new  = sat ? DEG_CAP : 8'(deg_wide);
        mm_new   = sat ? 7'd0 : mm_wide;

        weight   = FW'(pow10(32'(FRAC_DIGITS - 1) - 32'(fcount_reg)));
        frac_new = cur_frac + FW'(d) * weight;
    end

    always_comb
    begin
        hdr_next      = hdr_reg;
        started_next  = started_reg;
        rejected_next = rejected_reg;
        star_next     = star_reg;
        field_next    = field_reg;
        first_next    = first_reg;
        dot_next      = dot_reg;
        digit_next    = digit_reg;
        fcount_next   = fcount_reg;
        lat_deg_next  = lat_deg_reg;
        lat_mm_next   = lat_mm_reg;
        lat_frac_next = lat_frac_reg;
        lon_deg_next  = lon_deg_reg;
        lon_mm_next   = lon_mm_reg;
        lon_frac_next = lon_frac_reg;
        lat_bad_next  = lat_bad_reg;
        lon_bad_next  = lon_bad_reg;
        south_next    = south_reg;
        west_next     = west_reg;
        fix_nz_next   = fix_nz_reg;
        fix_bad_next  = fix_bad_reg;

        if (fire && is_lf)
        begin
            hdr_next      = 3'd0;
            started_next  = 1'b0;
            rejected_next = 1'b0;
            star_next     = 1'b0;
            field_next    = 3'd0;
            first_next    = 1'b1;
            dot_next      = 1'b0;
            digit_next    = 1'b0;
            fcount_next   = '0;
            lat_deg_next  = 8'd0;
            lat_mm_next   = 7'd0;
            lat_frac_next = '0;
            lon_deg_next  = 8'd0;
            lon_mm_next   = 7'd0;
            lon_frac_next = '0;
            lat_bad_next  = 1'b0;
            lon_bad_next  = 1'b0;
            south_next    = 1'b0;
            west_next     = 1'b0;
            fix_nz_next   = 1'b0;
            fix_bad_next  = 1'b0;
        end
        else if (fire && (started_reg || !is_blank))
        begin
            started_next = 1'b1;
            priority if (rejected_reg || star_reg)
            begin
                star_next = star_reg;
            end
            else if (hdr_reg < HDR_LEN)
            begin
                if (rx_byte == hdr_char(hdr_reg))
                    hdr_next = hdr_reg + 3'd1;
                else
                    rejected_next = 1'b1;
            end
            else if (rx_byte == CH_STAR)
            begin
                star_next = 1'b1;
            end
            else if (rx_byte == CH_COMMA)
            begin
                if (field_reg == FIELD_LAT && !digit_reg)
                    lat_bad_next = 1'b1;
                if (field_reg == FIELD_LON && !digit_reg)
                    lon_bad_next = 1'b1;
                if (field_reg != FIELD_MAX)
                    field_next = field_reg + 3'd1;
                fcount_next = '0;
                dot_next    = 1'b0;
                digit_next  = 1'b0;
                first_next  = 1'b1;
            end
            else
            begin
                unique case (field_reg)
                    FIELD_LAT, FIELD_LON:
                    begin
                        if (rx_byte == CH_DOT)
                        begin
                            if (dot_reg && sel_lon)
                                lon_bad_next = 1'b1;
                            if (dot_reg && !sel_lon)
                                lat_bad_next = 1'b1;
                            dot_next = 1'b1;
                        end
                        else if (is_digit)
                        begin
                            digit_next = 1'b1;
                            if (!dot_reg)
                            begin
                                if (sel_lon)
                                begin
                                    lon_deg_next = deg_new;
                                    lon_mm_next  = mm_new;
                                end
                                else
                                begin
                                    lat_deg_next = deg_new;
                                    lat_mm_next  = mm_new;
                                end
                            end
                            else if (fcount_reg < CW'(FRAC_DIGITS))
                            begin
                                // digits beyond the kept precision are dropped
                                if (sel_lon)
                                    lon_frac_next = frac_new;
                                else
                                    lat_frac_next = frac_new;
                                fcount_next = fcount_reg + CW'(1);
                            end
                        end
                    end
                    FIELD_NS:
                    begin
                        if (first_reg)
                            south_next = rx_byte == CH_S;
                    end
                    FIELD_EW:
                    begin
                        if (first_reg)
                            west_next = rx_byte == CH_W;
                    end
                    FIELD_FIX:
                    begin
                        if (rx_byte >= CH_ONE && rx_byte <= CH_NINE)
                            fix_nz_next = 1'b1;
                        else if (rx_byte == CH_DOT)
                            fix_bad_next = 1'b1;
                    end
                    default:
                    begin
                        fix_bad_next = fix_bad_reg;
                    end
                endcase
                first_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg      <= 3'd0;
            started_reg  <= 1'b0;
            rejected_reg <= 1'b0;
            star_reg     <= 1'b0;
            field_reg    <= 3'd0;
            first_reg    <= 1'b1;
            dot_reg      <= 1'b0;
            digit_reg    <= 1'b0;
            fcount_reg   <= '0;
            lat_deg_reg  <= 8'd0;
            lat_mm_reg   <= 7'd0;
            lat_frac_reg <= '0;
            lon_deg_reg  <= 8'd0;
            lon_mm_reg   <= 7'd0;
            lon_frac_reg <= '0;
            lat_bad_reg  <= 1'b0;
            lon_bad_reg  <= 1'b0;
            south_reg    <= 1'b0;
            west_reg     <= 1'b0;
            fix_nz_reg   <= 1'b0;
            fix_bad_reg  <= 1'b0;
        end
        else
        begin
            hdr_reg      <= hdr_next;
            started_reg  <= started_next;
            rejected_reg <= rejected_next;
            star_reg     <= star_next;
            field_reg    <= field_next;
            first_reg    <= first_next;
            dot_reg      <= dot_next;
            digit_reg    <= digit_next;
            fcount_reg   <= fcount_next;
            lat_deg_reg  <= lat_deg_next;
            lat_mm_reg   <= lat_mm_next;
            lat_frac_reg <= lat_frac_next;
            lon_deg_reg  <= lon_deg_next;
            lon_mm_reg   <= lon_mm_next;
            lon_frac_reg <= lon_frac_next;
            lat_bad_reg  <= lat_bad_next;
            lon_bad_reg  <= lon_bad_next;
            south_reg    <= south_next;
            west_reg     <= west_next;
            fix_nz_reg   <= fix_nz_next;
            fix_bad_reg  <= fix_bad_next;
        end
    end

    always_comb
    begin
        status.ok    = started_reg && hdr_reg == HDR_LEN && !rejected_reg
                       && field_reg >= FIELD_FIX && !lat_bad_reg && !lon_bad_reg
                       && fix_nz_reg && !fix_bad_reg;
        status.south = south_reg;
        status.west  = west_reg;
    end

    assign lat_deg  = lat_deg_reg;
    assign lat_mm   = lat_mm_reg;
    assign lat_frac = lat_frac_reg;
    assign lon_deg  = lon_deg_reg;
    assign lon_mm   = lon_mm_reg;
    assign lon_frac = lon_frac_reg;

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// NMEA GGA position parser testbench
// Feeds a character stream through the rx channel: a table of hand-picked
// lines first, then random sentences mixed with noise. A byte-level model
// of the parser predicts one result per line feed, and every result taken
// on the res channel is compared field by field. Both channels idle and
// stall at random.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nmea_gga_pkg::*;

    localparam int              CLK_PERIOD       = 20;
    localparam int              FRAC_DIGITS      = 5;
    localparam longint unsigned SCALE            = 100000;        // 10^FRAC_DIGITS
    localparam longint unsigned COORD_CAP        = 20000 * SCALE;
    localparam longint unsigned DEG_UNITS        = 10000000;
    localparam logic [47:0]     GGA_HEADER       = "$GPGGA";
    localparam int              RANDOM_BYTES     = 1170;
    localparam int              MIN_RANDOM_LINES = 20;
    localparam int              SETTLE_CYCLES    = 40;
    localparam int              RUN_LIMIT_NS     = 5000000;
    localparam int              NUM_DIRECTED     = 24;

    typedef struct packed {
        logic             acc;
        logic [LAT_W-1:0] lat;
        logic [LON_W-1:0] lon;
    } fix_result_t;

    typedef struct {
        string text;
        bit    typed;
        bit    acc;
        int    lat;
        int    lon;
    } line_case_t;

    typedef enum int {
        SINK_FREE,
        SINK_COIN,
        SINK_SPARSE,
        SINK_HELD
    } sink_mode_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    rx_valid = 1'b0;
    logic                    rx_ready;
    logic [7:0]              rx_byte = 8'h00;
    logic                    res_valid;
    logic                    res_ready = 1'b0;
    logic                    accepted;
    logic signed [LAT_W-1:0] latitude;
    logic signed [LON_W-1:0] longitude;

    fix_result_t expected_fixes[$];
    fix_result_t want_fix;
    logic [7:0]  line_buf[$];
    int          mismatch_count = 0;
    int          result_count = 0;
    int          burst_left = 0;
    int          bytes_sent = 0;
    int          lines_sent = 0;
    sink_mode_t  sink_mode = SINK_FREE;
    int          sink_phase_left = 0;

    // model of the line being parsed
    logic [2:0]  hdr_count;
    bit          in_line;
    bit          line_bad;
    bit          in_checksum;
    logic [2:0]  field_idx;
    bit          field_start;
    logic [33:0] lat_acc;
    logic [33:0] lon_acc;
    logic [2:0]  int_digits;
    logic [2:0]  frac_digits;
    bit          dot_found;
    bit          lat_err;
    bit          lon_err;
    bit          south;
    bit          west;
    bit          fix_set;
    bit          fix_err;

    line_case_t directed_lines [NUM_DIRECTED] = '{
        '{"\n",                                          1'b1, 1'b0, 0, 0},
        '{" \011\015\n",                                 1'b1, 1'b0, 0, 0},
        '{"$GPG\n",                                      1'b1, 1'b0, 0, 0},
        '{"$GPRMC,,4807.038,N,01131.000,E,1\n",          1'b1, 1'b0, 0, 0},
        '{"$GPGGA,,9000,N,18000,E,1\n",                  1'b1, 1'b1, 900000000, 1800000000},
        '{"$GPGGA,,9000,S,18000,W,1*5A\n",               1'b1, 1'b1, -900000000, -1800000000},
        '{"$GPGGA,,9000.00001,N,18000,E,1\n",            1'b1, 1'b0, 0, 0},
        '{"$GPGGA,,9000,N,18000.00001,E,1\n",            1'b1, 1'b0, 0, 0},
        '{"$GPGGA,,0000.00001,N,00000.00001,E,1\n",      1'b1, 1'b1, 1, 1},
        '{"$GPGGA,,0000.000,N,01131.000,E,1\n",          1'b1, 1'b0, 0, 0},
        '{"$GPGGA,,4807.038,N,,E,1\n",                   1'b1, 1'b0, 0, 0},
        '{"$GPGGA,,48.07.038,N,01131.000,E,1\n",         1'b1, 1'b0, 0, 0},
        '{"$GPGGA,,.,N,01131.000,E,1\n",                 1'b1, 1'b0, 0, 0},
        '{"$GPGGA,,99999999999,N,01131.000,E,1\n",       1'b1, 1'b0, 0, 0},
        '{"$GPGGA,,4807.038,N,01131.000,E,0\n",          1'b1, 1'b0, 0, 0},
        '{"$GPGGA,,4807.038,N,01131.000,E,1.0\n",        1'b1, 1'b0, 0, 0},
        '{"$GPGGA,,4807.038,N,01131.000,E\n",            1'b1, 1'b0, 0, 0},
        '{"$GPGGA,,,,,,,,,,,,\n",                        1'b1, 1'b0, 0, 0},
        '{"$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\015\n",
                                                         1'b0, 1'b0, 0, 0},
        '{" \011$GPGGA,,4807.0381234,S,01131.9999999,W,10*FF,junk\n",
                                                         1'b0, 1'b0, 0, 0},
        '{"$GPGGA,,4a8x07.038,Sx,011-31.000,Wy,x2y\n",   1'b0, 1'b0, 0, 0},
        '{"$GPGGA,,4807.038,n,01131.000,w,1\n",          1'b0, 1'b0, 0, 0},
        '{"$GPGGA\377,,4807,N,01131,E,1*,,,\n",          1'b0, 1'b0, 0, 0},
        '{"$GPGGA,,5959.99999,N,17959.99999,W,9\n",      1'b0, 1'b0, 0, 0}
    };

    nmea_gga_position_parser #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .accepted  (accepted),
        .latitude  (latitude),
        .longitude (longitude)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // line model
    // ------------------------------------------------------------------
    function automatic void clear_field();
        int_digits  = 3'd0;
        frac_digits = 3'd0;
        dot_found   = 1'b0;
        field_start = 1'b1;
    endfunction

    function automatic void clear_line();
        hdr_count   = 3'd0;
        in_line     = 1'b0;
        line_bad    = 1'b0;
        in_checksum = 1'b0;
        field_idx   = 3'd0;
        lat_acc     = '0;
        lon_acc     = '0;
        lat_err     = 1'b0;
        lon_err     = 1'b0;
        south       = 1'b0;
        west        = 1'b0;
        fix_set     = 1'b0;
        fix_err     = 1'b0;
        clear_field();
    endfunction

    function automatic void take_coord_char(input logic [7:0] c, inout logic [33:0] acc,
                                            inout bit err);
        longint unsigned nxt;
        longint unsigned weight;
        if (c == CH_DOT)
        begin
            if (dot_found)
                err = 1'b1;
            dot_found = 1'b1;
            return;
        end
        if (c < CH_ZERO || c > CH_NINE)
            return;
        if (!dot_found)
        begin
            if (int_digits < 3'd7)
                int_digits++;
            if (64'(acc) >= COORD_CAP)
                acc = 34'(COORD_CAP);
            else
            begin
                nxt = 64'(acc) * 64'd10 + 64'(c - CH_ZERO) * SCALE;
                acc = (nxt > COORD_CAP) ? 34'(COORD_CAP) : 34'(nxt);
            end
        end
        else if (frac_digits < FRAC_DIGITS)
        begin
            // digits past the kept fraction length are dropped
            weight = SCALE;
            repeat (int'(frac_digits) + 1) weight = weight / 10;
            acc = acc + 34'(64'(c - CH_ZERO) * weight);
            frac_digits++;
        end
    endfunction

    // ddmm.mmmmm scaled by 10^FRAC_DIGITS to 1e-7 degree, truncating
    function automatic bit scale_coord(input logic [33:0] s, input longint unsigned limit_deg,
                                       output longint unsigned units);
        longint unsigned deg;
        longint unsigned mins;
        units = 0;
        if (s == 0)
            return 1'b0;
        deg  = 64'(s) / (100 * SCALE);
        mins = 64'(s) - deg * 100 * SCALE;
        if (deg * 60 * SCALE + mins > limit_deg * 60 * SCALE)
            return 1'b0;
        units = deg * DEG_UNITS + (mins * DEG_UNITS) / (60 * SCALE);
        return units != 0;
    endfunction

    function automatic void parse_byte(input logic [7:0] c);
        fix_result_t     r;
        bit              ok;
        longint unsigned la;
        longint unsigned lo;
        if (c == CH_LF)
        begin
            la = 0;
            lo = 0;
            ok = in_line && hdr_count == HDR_LEN && !line_bad && field_idx >= FIELD_FIX &&
                 !lat_err && !lon_err && fix_set && !fix_err;
            if (ok)
                ok = scale_coord(lat_acc, 64'(LAT_LIMIT), la) &&
                     scale_coord(lon_acc, 64'(LON_LIMIT), lo);
            if (!ok)
            begin
                la = 0;
                lo = 0;
            end
            if (south)
                la = -la;
            if (west)
                lo = -lo;
            r.acc = ok;
            r.lat = LAT_W'(la);
            r.lon = LON_W'(lo);
            expected_fixes.push_back(r);
            clear_line();
            return;
        end

        if (!in_line)
        begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                return;
            in_line = 1'b1;
        end
        if (line_bad || in_checksum)
            return;
        if (hdr_count < HDR_LEN)
        begin
            if (c == GGA_HEADER[8 * (int'(HDR_LEN) - 1 - int'(hdr_count)) +: 8])
                hdr_count++;
            else
                line_bad = 1'b1;
            return;
        end
        if (c == CH_STAR)
        begin
            in_checksum = 1'b1;
            return;
        end
        if (c == CH_COMMA)
        begin
            if (field_idx == FIELD_LAT && int_digits == 0 && frac_digits == 0)
                lat_err = 1'b1;
            if (field_idx == FIELD_LON && int_digits == 0 && frac_digits == 0)
                lon_err = 1'b1;
            if (field_idx < FIELD_MAX)
                field_idx++;
            clear_field();
            return;
        end

        case (field_idx)
            FIELD_LAT: take_coord_char(c, lat_acc, lat_err);
            FIELD_NS:
            begin
                if (field_start)
                    south = (c == CH_S);
            end
            FIELD_LON: take_coord_char(c, lon_acc, lon_err);
            FIELD_EW:
            begin
                if (field_start)
                    west = (c == CH_W);
            end
            FIELD_FIX:
            begin
                if (c >= CH_ONE && c <= CH_NINE)
                    fix_set = 1'b1;
                else if (c == CH_DOT)
                    fix_err = 1'b1;
            end
            default: ;
        endcase
        field_start = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // random sentence builder
    // ------------------------------------------------------------------
    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void add_digits(input int n);
        repeat (n) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endfunction

    // decimal, zero padded to at least width digits
    function automatic void add_number(input int value, input int width);
        logic [7:0] digs[$];
        int         v;
        v = value;
        do
        begin
            digs.push_front(8'(int'(CH_ZERO) + v % 10));
            v = v / 10;
        end
        while (v != 0);
        while (digs.size() < width)
            digs.push_front(CH_ZERO);
        foreach (digs[i])
            line_buf.push_back(digs[i]);
    endfunction

    function automatic void add_coord(input int max_deg, input int deg_w);
        int deg;
        int nfrac;
        case ($urandom_range(0, 15))
            0: ;
            1:
            begin
                if ($urandom_range(0, 1) != 0)
                    add_text(".");
                else
                    add_text("12.34.5");
            end
            2: add_digits($urandom_range(8, 12));
            3: add_text("0000.000");
            4:
            begin
                add_number(max_deg * 100, deg_w + 2);
                add_text(".00000");
            end
            5:
            begin
                add_number(max_deg * 100, deg_w + 2);
                add_text(".00001");
            end
            6:
            begin
                add_digits(2);
                line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
                add_digits(2);
                add_text(".5");
            end
            default:
            begin
                deg = $urandom_range(0, max_deg);
                add_number(deg, ($urandom_range(0, 3) == 0) ? 1 : deg_w);
                add_number((deg == max_deg) ? 0 : $urandom_range(0, 59), 2);
                nfrac = $urandom_range(0, 8);
                if (nfrac > 0 || $urandom_range(0, 1) != 0)
                    line_buf.push_back(CH_DOT);
                add_digits(nfrac);
            end
        endcase
    endfunction

    function automatic void add_hemi(input logic [7:0] plain, input logic [7:0] negate);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: line_buf.push_back(plain);
            4, 5, 6, 7: line_buf.push_back(negate);
            8: ;
            default: line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
        endcase
        if ($urandom_range(0, 9) == 0)
            line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
    endfunction

    function automatic void build_line();
        int cut;
        line_buf.delete();
        if ($urandom_range(0, 11) == 0)
        begin
            repeat ($urandom_range(1, 24)) line_buf.push_back(8'($urandom_range(0, 255)));
            line_buf.push_back(CH_LF);
            return;
        end
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 3))
                line_buf.push_back(($urandom_range(0, 1) != 0) ? CH_SPACE :
                                   8'($urandom_range(CH_TAB, CH_CR)));
        end
        case ($urandom_range(0, 19))
            0: add_text("$GPRMC");
            1: add_text("$GPG");
            2: add_text("$GNGGA");
            default: add_text("$GPGGA");
        endcase
        // most lines carry all seven fields; a few stop short
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : 6;
        for (int f = 1; f <= cut; f++)
        begin
            line_buf.push_back(CH_COMMA);
            case (f)
                1: add_digits($urandom_range(0, 6));
                2: add_coord(90, 2);
                3: add_hemi("N", CH_S);
                4: add_coord(180, 3);
                5: add_hemi("E", CH_W);
                default:
                begin
                    case ($urandom_range(0, 9))
                        0: line_buf.push_back(CH_ZERO);
                        1: ;
                        2: add_text("1.0");
                        3: add_text("12");
                        4: line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
                        default: line_buf.push_back(8'($urandom_range(CH_ONE, CH_NINE)));
                    endcase
                end
            endcase
        end
        if (cut == 6 && $urandom_range(0, 1) != 0)
            add_text(",08,0.9,545.4,M,46.9,M,,");
        if ($urandom_range(0, 9) < 6)
        begin
            line_buf.push_back(CH_STAR);
            repeat (2) line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
        if ($urandom_range(0, 1) != 0)
            line_buf.push_back(CH_CR);
        if ($urandom_range(0, 19) == 0)
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        line_buf.push_back(CH_LF);
    endfunction

    // ------------------------------------------------------------------
    // rx side
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0)
        begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                                                      $urandom_range(1, 24);
        end
        burst_left--;
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!rx_ready);
        parse_byte(b);
    endtask

    task automatic drain_fixes();
        rx_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_fixes.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // res side
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (sink_phase_left == 0)
        begin
            sink_mode = sink_mode_t'($urandom_range(0, 3));
            sink_phase_left = (sink_mode == SINK_HELD) ? $urandom_range(1, 30) :
                                                         $urandom_range(20, 150);
        end
        sink_phase_left--;
        case (sink_mode)
            SINK_FREE:   res_ready <= 1'b1;
            SINK_COIN:   res_ready <= ($urandom_range(0, 1) != 0);
            SINK_SPARSE: res_ready <= ($urandom_range(0, 5) == 0);
            default:     res_ready <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_fixes.size() == 0)
                report_mismatch($sformatf("unexpected result: accepted %0b lat %0d lon %0d",
                                          accepted, latitude, longitude));
            else
            begin
                want_fix = expected_fixes.pop_front();
                if (accepted !== want_fix.acc)
                    report_mismatch($sformatf("result %0d accepted: got %0b want %0b",
                                              result_count, accepted, want_fix.acc));
                if (latitude !== want_fix.lat)
                    report_mismatch($sformatf("result %0d latitude: got %0d want %0d",
                                              result_count, latitude, $signed(want_fix.lat)));
                if (longitude !== want_fix.lon)
                    report_mismatch($sformatf("result %0d longitude: got %0d want %0d",
                                              result_count, longitude, $signed(want_fix.lon)));
            end
            result_count++;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clear_line();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_lines[i])
        begin
            for (int k = 0; k < directed_lines[i].text.len(); k++)
                send_byte(directed_lines[i].text[k]);
            if (directed_lines[i].typed)
                expected_fixes[expected_fixes.size() - 1] = '{
                    acc: directed_lines[i].acc,
                    lat: LAT_W'(directed_lines[i].lat),
                    lon: LON_W'(directed_lines[i].lon)
                };
        end
        drain_fixes();

        while (bytes_sent < RANDOM_BYTES || lines_sent < MIN_RANDOM_LINES)
        begin
            build_line();
            foreach (line_buf[i])
                send_byte(line_buf[i]);
            bytes_sent += line_buf.size();
            lines_sent++;
            if (lines_sent % 10 == 0)
                drain_fixes();
        end

        rx_valid <= 1'b0;
        while (expected_fixes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/nmea_gga_pkg.sv
src/nmea_gga_scan.sv
src/nmea_gga_position_parser.sv
test/testbench.sv
